>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files of the frame parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define HTFP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("frame parser assertion failed");

// An implication whose consequent is checked in the cycle after the antecedent.
`define HTFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame parser assertion failed");

`endif

>>> rtl/core/htfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfp_pkg
// Types and constants shared by the header/tail frame parser modules.
// ----------------------------------------------------------------------------
package htfp_pkg;

    // Received byte word.
    typedef struct packed {
        logic [7:0] rx_byte;
    } t_rx_word;

    // Result word: decoded target report.
    typedef struct packed {
        logic [15:0] coord_x;
        logic [15:0] coord_y;
        logic [7:0]  target_lost;
    } t_res_word;

    // Configuration register index and write word.
    typedef logic [1:0] t_reg_idx;

    localparam t_reg_idx REG_FIRST_HDR  = 2'd0;
    localparam t_reg_idx REG_SECOND_HDR = 2'd1;
    localparam t_reg_idx REG_TAIL       = 2'd2;

    typedef struct packed {
        t_reg_idx   reg_index;
        logic [7:0] wr_data;
    } t_cfg_word;

    // Current register settings handed to the parser.
    typedef struct packed {
        logic [7:0] first_hdr;
        logic [7:0] second_hdr;
        logic [7:0] tail;
    } t_cfg_regs;

    localparam logic [7:0] FIRST_HDR_RST  = 8'h2C;
    localparam logic [7:0] SECOND_HDR_RST = 8'h12;
    localparam logic [7:0] TAIL_RST       = 8'h5B;

    // Parse phase.
    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_HDR2 = 2'd1,
        PH_BODY = 2'd2
    } t_phase;

    // Frame positions that carry payload: bytes 2 through 6.
    localparam int BODY_FIRST = 2;
    localparam int BODY_BYTES = 5;

endpackage

>>> rtl/core/htfp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfp_if
// Valid/ready channels of the frame parser: received bytes, results and
// configuration writes.
// ----------------------------------------------------------------------------
interface htfp_rx_if
    import htfp_pkg::*;
    ();
    logic     valid;
    logic     ready;
    t_rx_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface htfp_res_if
    import htfp_pkg::*;
    ();
    logic      valid;
    logic      ready;
    t_res_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface htfp_cfg_if
    import htfp_pkg::*;
    ();
    logic      valid;
    logic      ready;
    t_cfg_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/htfp_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfp_cfg_regs
// Header and tail match registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module htfp_cfg_regs
    import htfp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_wr_en,
    input  t_cfg_word i_wr_word,
    output t_cfg_regs o_regs
);

    t_cfg_regs r_regs;
    t_cfg_regs n_regs;

    // Decode the register index; an index past the list is ignored.
    always_comb begin
        n_regs = r_regs;
        if (i_wr_en) begin
            case (i_wr_word.reg_index)
                REG_FIRST_HDR:  n_regs.first_hdr  = i_wr_word.wr_data;
                REG_SECOND_HDR: n_regs.second_hdr = i_wr_word.wr_data;
                REG_TAIL:       n_regs.tail       = i_wr_word.wr_data;
                default:        n_regs            = r_regs;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.first_hdr  <= FIRST_HDR_RST;
            r_regs.second_hdr <= SECOND_HDR_RST;
            r_regs.tail       <= TAIL_RST;
        end else begin
            r_regs <= n_regs;
        end
    end

    assign o_regs = r_regs;

endmodule

>>> rtl/core/htfp_parser.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// htfp_parser
// Frame state machine: hunts for the two header bytes, counts the frame,
// keeps the payload bytes and checks the tail on the last byte.
// ----------------------------------------------------------------------------
module htfp_parser
    import htfp_pkg::*;
#(
    parameter int FRAME_BYTES = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    input  t_cfg_regs  i_regs,
    output logic       o_hit,
    output t_res_word  o_res
);

    localparam int CNT_W = $clog2(FRAME_BYTES + 1);
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_BYTES - 1);

    t_phase           r_phase;
    t_phase           n_phase;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [7:0]       r_body [BODY_BYTES];
    logic [7:0]       n_body [BODY_BYTES];
    logic             hit;

    // Next phase and count for the word that is accepted in this cycle.
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        hit     = 1'b0;
        if (i_accept) begin
            case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == i_regs.first_hdr) begin
                        n_phase = PH_HDR2;
                        n_count = CNT_W'(1);
                    end
                end
                PH_HDR2: begin
                    if (i_rx_byte == i_regs.second_hdr) begin
                        n_phase = PH_BODY;
                        n_count = CNT_W'(2);
                    end else begin
                        n_phase = PH_HUNT;
                        n_count = '0;
                    end
                end
                PH_BODY: begin
                    if (r_count == LAST_IDX) begin
                        // The current word is the tail of the frame.
                        hit     = (i_rx_byte == i_regs.tail);
                        n_phase = PH_HUNT;
                        n_count = '0;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                    n_count = '0;
                end
            endcase
        end
    end

    // Keep the payload bytes at their frame positions.
    always_comb begin
        for (int k = 0; k < BODY_BYTES; k++) begin
            n_body[k] = r_body[k];
            if (i_accept && r_phase == PH_BODY && r_count == CNT_W'(BODY_FIRST + k)) begin
                n_body[k] = i_rx_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_body <= n_body;
    end

    // Big-endian coordinates and the lost flag.
    assign o_hit             = hit;
    assign o_res.coord_x     = {r_body[0], r_body[1]};
    assign o_res.coord_y     = {r_body[2], r_body[3]};
    assign o_res.target_lost = r_body[4];

    // While hunting, no frame byte is held.
    `HTFP_ASSERT(a_hunt_count_zero, i_clk, i_rst_n, r_phase != PH_HUNT || r_count == '0)
    // The count never runs past the last frame position.
    `HTFP_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= LAST_IDX)
    // The second header position is left after one word.
    `HTFP_ASSERT_NEXT(a_hdr2_once, i_clk, i_rst_n,
        i_accept && r_phase == PH_HDR2, r_phase != PH_HDR2)

endmodule

>>> rtl/core/htfp_out_reg.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// htfp_out_reg
// Result register between the parser and the result channel.
// ----------------------------------------------------------------------------
module htfp_out_reg
    import htfp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_res_word i_res,
    input  logic      i_ready,
    output logic      o_free,
    output logic      o_valid,
    output t_res_word o_res
);

    logic      r_valid;
    logic      n_valid;
    t_res_word r_res;

    // The register can take a new word when it is empty or being drained.
    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    // A held result is never overwritten before it is taken.
    `HTFP_ASSERT(a_no_overwrite, i_clk, i_rst_n, !(i_load && r_valid && !i_ready))
    // A loaded result is shown in the next cycle.
    `HTFP_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, i_load, r_valid)

endmodule

>>> rtl/core/header_tail_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// header_tail_frame_parser
// Fixed-length serial frame parser with header and tail checks.
// ----------------------------------------------------------------------------
// The parser takes one received byte word per clock cycle. It looks for the
// first header byte, then needs the second header byte in the next word,
// collects FRAME_BYTES words in all and, when the last word equals the tail
// byte, delivers x, y and the lost flag in the next cycle. Each word is
// handled in the cycle it is accepted; the single result register sets the
// rate, so input is taken every cycle unless a result is waiting and the
// result channel is not ready. The user must write the match values through
// the configuration channel only while the parser is idle; nothing checks it.
module header_tail_frame_parser
    import htfp_pkg::*;
#(
    parameter int FRAME_BYTES = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    htfp_rx_if.sink          i_rx,
    htfp_res_if.source       o_res,
    htfp_cfg_if.sink         i_cfg
);

    t_cfg_regs regs;
    t_res_word parse_res;
    logic      parse_hit;
    logic      out_free;
    logic      rx_accept;

    // Byte words are taken whenever the result register has room.
    assign i_rx.ready  = out_free;
    assign rx_accept   = i_rx.valid && out_free;
    assign i_cfg.ready = 1'b1;

    htfp_cfg_regs u_cfg_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg.valid),
        .i_wr_word (i_cfg.data),
        .o_regs    (regs)
    );

    htfp_parser #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (rx_accept),
        .i_rx_byte (i_rx.data.rx_byte),
        .i_regs    (regs),
        .o_hit     (parse_hit),
        .o_res     (parse_res)
    );

    // The payload bytes are final when the tail word arrives, so the
    // tail byte itself is not needed in the result.
    t_res_word load_res;
    always_comb begin
        load_res = parse_res;
        if (rx_accept && FRAME_BYTES == BODY_FIRST + BODY_BYTES) begin
            load_res.target_lost = parse_res.target_lost;
        end
    end

    htfp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (parse_hit),
        .i_res   (load_res),
        .i_ready (o_res.ready),
        .o_free  (out_free),
        .o_valid (o_res.valid),
        .o_res   (o_res.data)
    );

endmodule
